/* rtl/rmh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmh_pkg
// Shared constants, transaction types and compare function for the running
// median block.
// ----------------------------------------------------------------------------
package rmh_pkg;

  localparam int HEAP_DEPTH = 512;
  localparam int DW         = 32;
  localparam int LEVELS     = $clog2(HEAP_DEPTH + 1);
  localparam int NW         = LEVELS;
  localparam int CW         = $clog2(HEAP_DEPTH + 1);
  localparam int LW         = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_SIFT = 1'b1;

  typedef struct packed {
    logic          valid;
    logic          op;
    logic [DW-1:0] val;
    logic [NW-1:0] par;
    logic          side;
    logic [NW-1:0] tgt;
    logic [LW-1:0] lvl;
    logic [CW-1:0] n;
  } rmh_tok_t;

  typedef struct packed {
    logic          valid;
    logic          last;
    logic [DW-1:0] val;
  } rmh_wb_t;

  function automatic logic ranks_above(input logic is_max, input logic [DW-1:0] a,
                                       input logic [DW-1:0] b);
    return is_max ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
  endfunction

endpackage
`default_nettype wire

/* rtl/rmh_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmh_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rmh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      wr_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                          wr_data_i,
  input  wire logic                                      rd_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]                          rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/rmh_root.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmh_root
// Top entry of one heap, held in a register; starts push and replace-top
// transactions down the level chain.
// ----------------------------------------------------------------------------
module rmh_root import rmh_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     is_max_i,
  input  wire rmh_tok_t cmd_i,
  input  wire rmh_wb_t  wb_i,
  output logic [DW-1:0] top_o,
  output rmh_tok_t      tok_o,
  output logic          done_o
);

  logic [DW-1:0] root_q, root_d;
  logic [NW-1:0] node1;

  always_comb begin
    root_d = root_q;
    tok_o  = '0;
    done_o = 1'b0;
    node1  = cmd_i.tgt >> (cmd_i.lvl - LW'(1));
    if (cmd_i.valid) begin
      if (cmd_i.op == OP_PUSH) begin
        if (cmd_i.lvl == '0) begin
          root_d = cmd_i.val;
          done_o = 1'b1;
        end else begin
          tok_o.valid = 1'b1;
          tok_o.op    = OP_PUSH;
          tok_o.tgt   = cmd_i.tgt;
          tok_o.lvl   = cmd_i.lvl;
          tok_o.n     = cmd_i.n;
          tok_o.par   = node1 >> 1;
          tok_o.side  = node1[0];
          if (ranks_above(is_max_i, cmd_i.val, root_q)) begin
            root_d    = cmd_i.val;
            tok_o.val = root_q;
          end else begin
            tok_o.val = cmd_i.val;
          end
        end
      end else begin
        if (cmd_i.n < CW'(2)) begin
          root_d = cmd_i.val;
          done_o = 1'b1;
        end else begin
          tok_o.valid = 1'b1;
          tok_o.op    = OP_SIFT;
          tok_o.val   = cmd_i.val;
          tok_o.par   = NW'(1);
          tok_o.n     = cmd_i.n;
        end
      end
    end
    if (wb_i.valid) begin
      root_d = wb_i.val;
      done_o = wb_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
  end

  assign top_o = root_q;

endmodule
`default_nettype wire

/* rtl/rmh_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmh_cell
// One heap level: drives the sibling-pair RAM of its level, places or swaps
// the value handed down and returns write-backs to the level above.
// ----------------------------------------------------------------------------
module rmh_cell import rmh_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            is_max_i,
  input  wire logic [LW-1:0]   lvl_i,
  input  wire rmh_tok_t        tok_i,
  input  wire rmh_wb_t         wb_i,
  output rmh_tok_t             tok_o,
  output rmh_wb_t              wb_o,
  output logic                 done_o,
  output logic                 rd_en_o,
  output logic [NW-1:0]        rd_addr_o,
  input  wire logic [2*DW-1:0] rd_data_i,
  output logic                 wr_en_o,
  output logic [NW-1:0]        wr_addr_o,
  output logic [2*DW-1:0]      wr_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  logic [1:0]      st_q, st_d;
  logic            op_q;
  logic [DW-1:0]   val_q;
  logic [NW-1:0]   par_q;
  logic            side_q, side_d;
  logic [NW-1:0]   tgt_q;
  logic [LW-1:0]   lvl_q;
  logic [CW-1:0]   n_q;
  logic [2*DW-1:0] pair_q, pair_d;

  logic [DW-1:0]   h0, h1, e, bestv;
  logic            stay, sel;
  logic [NW-1:0]   child, node;
  logic [NW-1:0]   lvl_mask;

  function automatic logic [2*DW-1:0] set_half(input logic [2*DW-1:0] p, input logic s,
                                               input logic [DW-1:0] v);
    logic [2*DW-1:0] r;
    r = p;
    if (s) begin
      r[2*DW-1:DW] = v;
    end else begin
      r[DW-1:0] = v;
    end
    return r;
  endfunction

  assign lvl_mask  = ~(NW'(1) << (lvl_i - LW'(1)));
  assign rd_en_o   = tok_i.valid;
  assign rd_addr_o = tok_i.par & lvl_mask;
  assign wr_addr_o = par_q & lvl_mask;
  assign h0        = rd_data_i[DW-1:0];
  assign h1        = rd_data_i[2*DW-1:DW];

  always_comb begin
    st_d      = st_q;
    side_d    = side_q;
    pair_d    = pair_q;
    tok_o     = '0;
    wb_o      = '0;
    done_o    = 1'b0;
    wr_en_o   = 1'b0;
    wr_data_o = rd_data_i;
    e         = side_q ? h1 : h0;
    bestv     = val_q;
    stay      = 1'b1;
    sel       = 1'b0;
    child     = '0;
    node      = tgt_q >> (lvl_q - lvl_i - LW'(1));
    case (st_q)
      ST_IDLE: begin
        if (tok_i.valid) begin
          st_d   = ST_RD;
          side_d = tok_i.side;
        end
      end
      ST_RD: begin
        st_d = ST_IDLE;
        if (op_q == OP_PUSH) begin
          if (lvl_q == lvl_i) begin
            wr_en_o   = 1'b1;
            wr_data_o = set_half(rd_data_i, side_q, val_q);
            done_o    = 1'b1;
          end else begin
            tok_o.valid = 1'b1;
            tok_o.op    = OP_PUSH;
            tok_o.tgt   = tgt_q;
            tok_o.lvl   = lvl_q;
            tok_o.n     = n_q;
            tok_o.par   = node >> 1;
            tok_o.side  = node[0];
            if (ranks_above(is_max_i, val_q, e)) begin
              wr_en_o   = 1'b1;
              wr_data_o = set_half(rd_data_i, side_q, val_q);
              tok_o.val = e;
            end else begin
              tok_o.val = val_q;
            end
          end
        end else begin
          if (ranks_above(is_max_i, h0, val_q)) begin
            stay  = 1'b0;
            sel   = 1'b0;
            bestv = h0;
          end
          if (({1'b0, par_q, 1'b1}) <= (NW + 2)'(n_q) && ranks_above(is_max_i, h1, bestv)) begin
            stay  = 1'b0;
            sel   = 1'b1;
            bestv = h1;
          end
          wb_o.valid = 1'b1;
          wb_o.last  = stay;
          wb_o.val   = stay ? val_q : bestv;
          child      = {par_q[NW-2:0], sel};
          if (!stay) begin
            side_d = sel;
            pair_d = rd_data_i;
            if (({1'b0, child, 1'b0}) > (NW + 2)'(n_q)) begin
              wr_en_o   = 1'b1;
              wr_data_o = set_half(rd_data_i, sel, val_q);
              done_o    = 1'b1;
            end else begin
              tok_o.valid = 1'b1;
              tok_o.op    = OP_SIFT;
              tok_o.val   = val_q;
              tok_o.par   = child;
              tok_o.n     = n_q;
              st_d        = ST_WB;
            end
          end
        end
      end
      ST_WB: begin
        if (wb_i.valid) begin
          wr_en_o   = 1'b1;
          wr_data_o = set_half(pair_q, side_q, wb_i.val);
          pair_d    = set_half(pair_q, side_q, wb_i.val);
          done_o    = wb_i.last;
          st_d      = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_d;
    pair_q <= pair_d;
    if (st_q == ST_IDLE && tok_i.valid) begin
      op_q  <= tok_i.op;
      val_q <= tok_i.val;
      par_q <= tok_i.par;
      tgt_q <= tok_i.tgt;
      lvl_q <= tok_i.lvl;
      n_q   <= tok_i.n;
    end
  end

endmodule
`default_nettype wire

/* rtl/rmh_heap.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmh_heap
// One heap as a chain of level cells below a register root; each level keeps
// its entries as sibling pairs in its own RAM.
// ----------------------------------------------------------------------------
module rmh_heap import rmh_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     is_max_i,
  input  wire rmh_tok_t cmd_i,
  output logic [DW-1:0] top_o,
  output logic          done_o
);

  rmh_tok_t          tok [1:LEVELS];
  rmh_wb_t           wb  [1:LEVELS];
  logic [LEVELS-1:0] dn;

  assign wb[LEVELS] = '0;

  rmh_root u_root (
    .clk_i    (clk_i),
    .is_max_i (is_max_i),
    .cmd_i    (cmd_i),
    .wb_i     (wb[1]),
    .top_o    (top_o),
    .tok_o    (tok[1]),
    .done_o   (dn[0])
  );

  for (genvar k = 1; k < LEVELS; k++) begin : g_lvl
    localparam int Depth = 2 ** (k - 1);
    localparam int Aw    = (Depth > 1) ? $clog2(Depth) : 1;

    logic            rd_en, wr_en;
    logic [NW-1:0]   rd_addr, wr_addr;
    logic [2*DW-1:0] rd_data, wr_data;

    rmh_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .is_max_i  (is_max_i),
      .lvl_i     (LW'(k)),
      .tok_i     (tok[k]),
      .wb_i      (wb[k+1]),
      .tok_o     (tok[k+1]),
      .wb_o      (wb[k]),
      .done_o    (dn[k]),
      .rd_en_o   (rd_en),
      .rd_addr_o (rd_addr),
      .rd_data_i (rd_data),
      .wr_en_o   (wr_en),
      .wr_addr_o (wr_addr),
      .wr_data_o (wr_data)
    );

    rmh_ram #(
      .WIDTH (2 * DW),
      .DEPTH (Depth)
    ) u_ram (
      .clk_i     (clk_i),
      .wr_en_i   (wr_en),
      .wr_addr_i (wr_addr[Aw-1:0]),
      .wr_data_i (wr_data),
      .rd_en_i   (rd_en),
      .rd_addr_i (rd_addr[Aw-1:0]),
      .rd_data_o (rd_data)
    );
  end

  assign done_o = |dn;

endmodule
`default_nettype wire

/* rtl/running_median_two_heaps.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median of signed 32-bit samples kept in a max-heap and a min-heap.
// ----------------------------------------------------------------------------
// Usage:
//   A sample transaction is taken on sample_i at a rising edge with start high
//   and busy low. Exactly one result follows: median_o and dropped_o are valid
//   for the single cycle in which valid_o is high. The receiver cannot stall;
//   the result must be taken in that cycle.
//   A dropped sample goes from acceptance straight to the result state. An
//   inserted sample walks the level chain of one or both heaps; a cell reads
//   its pair RAM while the level above decides.
//   busy stays high until the result is issued; the next start can be taken
//   in the cycle valid_o is high. One sample is in flight at a time.
//   Reset empties both heaps at once (counts cleared); no clearing pass runs.
// ----------------------------------------------------------------------------
module running_median_two_heaps import rmh_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [DW-1:0] sample_i,
  output logic                      valid_o,
  output logic signed [DW-1:0]      median_o,
  output logic                      dropped_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]    st_q, st_d;
  logic [CW-1:0] lc_q, lc_d, uc_q, uc_d;
  rmh_tok_t      lo_cmd_q, lo_cmd_d, up_cmd_q, up_cmd_d;
  logic          lo_dn_q, lo_dn_d, up_dn_q, up_dn_d;
  logic          drop_q, drop_d;
  logic          valid_q;
  logic [DW-1:0] med_q, med_d;
  logic [DW-1:0] lo_top, up_top;
  logic          lo_done, up_done;
  logic          accept;
  logic [DW:0]   sum, sum_adj;

  function automatic logic [LW-1:0] lead_one(input logic [NW-1:0] x);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < NW; i++) begin
      if (x[i]) begin
        r = LW'(i);
      end
    end
    return r;
  endfunction

  function automatic rmh_tok_t mk_push(input logic [DW-1:0] v, input logic [CW-1:0] n);
    rmh_tok_t t;
    t       = '0;
    t.valid = 1'b1;
    t.op    = OP_PUSH;
    t.val   = v;
    t.n     = n;
    t.tgt   = NW'(n) + NW'(1);
    t.lvl   = lead_one(t.tgt);
    return t;
  endfunction

  function automatic rmh_tok_t mk_sift(input logic [DW-1:0] v, input logic [CW-1:0] n);
    rmh_tok_t t;
    t       = '0;
    t.valid = 1'b1;
    t.op    = OP_SIFT;
    t.val   = v;
    t.n     = n;
    return t;
  endfunction

  assign accept  = start && !busy;
  assign busy    = (st_q != ST_IDLE);
  assign sum     = {lo_top[DW-1], lo_top} + {up_top[DW-1], up_top};
  assign sum_adj = sum + {{DW{1'b0}}, sum[DW]};

  always_comb begin
    st_d     = st_q;
    lc_d     = lc_q;
    uc_d     = uc_q;
    lo_cmd_d = '0;
    up_cmd_d = '0;
    lo_dn_d  = lo_dn_q;
    up_dn_d  = up_dn_q;
    drop_d   = drop_q;
    med_d    = med_q;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          drop_d  = 1'b0;
          lo_dn_d = 1'b1;
          up_dn_d = 1'b1;
          st_d    = ST_RUN;
          if (lc_q == uc_q) begin
            if (lc_q >= CW'(HEAP_DEPTH)) begin
              drop_d = 1'b1;
              st_d   = ST_FIN;
            end else if (uc_q != '0 && $signed(sample_i) > $signed(up_top)) begin
              up_cmd_d = mk_sift(sample_i, uc_q);
              lo_cmd_d = mk_push(up_top, lc_q);
              lo_dn_d  = 1'b0;
              up_dn_d  = 1'b0;
              lc_d     = lc_q + CW'(1);
            end else begin
              lo_cmd_d = mk_push(sample_i, lc_q);
              lo_dn_d  = 1'b0;
              lc_d     = lc_q + CW'(1);
            end
          end else begin
            if (lc_q != '0 && $signed(sample_i) < $signed(lo_top)) begin
              lo_cmd_d = mk_sift(sample_i, lc_q);
              up_cmd_d = mk_push(lo_top, uc_q);
              lo_dn_d  = 1'b0;
              up_dn_d  = 1'b0;
              uc_d     = uc_q + CW'(1);
            end else begin
              up_cmd_d = mk_push(sample_i, uc_q);
              up_dn_d  = 1'b0;
              uc_d     = uc_q + CW'(1);
            end
          end
        end
      end
      ST_RUN: begin
        lo_dn_d = lo_dn_q | lo_done;
        up_dn_d = up_dn_q | up_done;
        if (lo_dn_d && up_dn_d) begin
          st_d = ST_FIN;
        end
      end
      ST_FIN: begin
        st_d = ST_IDLE;
        if (lc_q == '0) begin
          med_d = (uc_q == '0) ? '0 : up_top;
        end else if (uc_q == '0 || lc_q != uc_q) begin
          med_d = lo_top;
        end else begin
          med_d = sum_adj[DW:1];
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      lc_q     <= '0;
      uc_q     <= '0;
      lo_cmd_q <= '0;
      up_cmd_q <= '0;
      lo_dn_q  <= 1'b0;
      up_dn_q  <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      lc_q     <= lc_d;
      uc_q     <= uc_d;
      lo_cmd_q <= lo_cmd_d;
      up_cmd_q <= up_cmd_d;
      lo_dn_q  <= lo_dn_d;
      up_dn_q  <= up_dn_d;
      valid_q  <= (st_q == ST_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    drop_q <= drop_d;
    med_q  <= med_d;
  end

  rmh_heap u_lower (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .is_max_i (1'b1),
    .cmd_i    (lo_cmd_q),
    .top_o    (lo_top),
    .done_o   (lo_done)
  );

  rmh_heap u_upper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .is_max_i (1'b0),
    .cmd_i    (up_cmd_q),
    .top_o    (up_top),
    .done_o   (up_done)
  );

  assign valid_o   = valid_q;
  assign median_o  = med_q;
  assign dropped_o = drop_q;

`ifndef SYNTHESIS
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result without a transaction in flight");

  a_count_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lc_q == uc_q) || (lc_q == uc_q + CW'(1)))
    else $error("heap counts out of balance");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && dropped_o) |-> (lc_q == CW'(HEAP_DEPTH) && uc_q == CW'(HEAP_DEPTH)))
    else $error("sample dropped while heaps not full");
`endif

endmodule
`default_nettype wire

/* verif/tb_running_median_two_heaps.sv */
// ----------------------------------------------------------------------------
// tb_running_median_two_heaps
// Self-checking bench for the running median block. A directed table of
// sample transactions, then random samples, runs until both heaps are full
// and well past that point. Results are checked against a sorted-set median
// predictor or a fixed table value. Drops are covered once the set is full.
// ----------------------------------------------------------------------------
module tb_running_median_two_heaps;
  import rmh_pkg::*;

  localparam int CAPACITY  = 2 * HEAP_DEPTH;
  localparam int N_RANDOM  = 1600;
  localparam int WD_LIMIT  = 5000;
  localparam int TAIL_WAIT = 40;

  typedef struct {
    logic signed [DW-1:0] med;
    logic                 drp;
  } median_res_t;

  typedef struct {
    logic signed [DW-1:0] smp;
    bit                   fixed;
    logic signed [DW-1:0] med;
    logic                 drp;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic signed [DW-1:0] sample_i;
  logic                 valid_o;
  logic signed [DW-1:0] median_o;
  logic                 dropped_o;

  logic signed [DW-1:0] sorted_samples[$];
  median_res_t          pending_medians[$];
  dir_row_t             dir_rows[20];
  int                   errors;
  int                   items_sent;
  int                   results_seen;
  int                   drops_seen;
  int                   idle_cycles;
  bit                   accepted_now;
  bit                   idling_on;

  running_median_two_heaps u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .sample_i (sample_i),
    .valid_o  (valid_o),
    .median_o (median_o),
    .dropped_o(dropped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, exp, results_seen);
  endtask

  function automatic median_res_t insert_and_median(input logic signed [DW-1:0] v);
    median_res_t r;
    int          idx;
    int          n;
    longint      s;
    r.drp = 1'b0;
    if (sorted_samples.size() >= CAPACITY) begin
      r.drp = 1'b1;
    end else begin
      idx = 0;
      while (idx < sorted_samples.size() && sorted_samples[idx] <= v) idx++;
      sorted_samples.insert(idx, v);
    end
    n = sorted_samples.size();
    if (n[0]) begin
      r.med = sorted_samples[(n - 1) / 2];
    end else begin
      s = longint'(sorted_samples[n/2 - 1]) + longint'(sorted_samples[n/2]);
      r.med = DW'(s / 2);
    end
    return r;
  endfunction

  task automatic send_sample(input logic signed [DW-1:0] v, input bit fixed,
                             input logic signed [DW-1:0] med, input logic drp);
    median_res_t r;
    while (idling_on && $urandom_range(99) < 31) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start    <= 1'b1;
    sample_i <= v;
    do @(posedge clk_i); while (busy);
    accepted_now = 1'b1;
    r = insert_and_median(v);
    if (fixed) begin
      r.med = med;
      r.drp = drp;
    end
    if (r.drp) drops_seen++;
    pending_medians.push_back(r);
    items_sent++;
  endtask

  function automatic logic signed [DW-1:0] random_sample();
    case ($urandom_range(3))
      0: return $signed($urandom_range(16)) - 8;
      1: return 32'h7fff_fff0 + $urandom_range(15);
      2: return 32'h8000_0000 + $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    median_res_t e;
    if (rst_ni && valid_o) begin
      results_seen++;
      if (pending_medians.size() == 0) begin
        report_mismatch("unexpected result", median_o, 0);
      end else begin
        e = pending_medians.pop_front();
        if (median_o !== e.med) report_mismatch("median", median_o, e.med);
        if (dropped_o !== e.drp) report_mismatch("dropped", dropped_o, e.drp);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WD_LIMIT) begin
      @(posedge clk_i);
      #1;
      if (accepted_now || valid_o) idle_cycles = 0;
      else idle_cycles++;
      accepted_now = 1'b0;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    errors       = 0;
    items_sent   = 0;
    results_seen = 0;
    drops_seen   = 0;
    accepted_now = 1'b0;
    idling_on    = 1'b1;
    start        = 1'b0;
    sample_i     = '0;
    rst_ni       = 1'b0;
    dir_rows = '{
      '{32'sh8000_0000, 1'b1, 32'sh8000_0000, 1'b0},
      '{32'sh7fff_ffff, 1'b1, 32'sh0000_0000, 1'b0},
      '{32'sh0000_0000, 1'b1, 32'sh0000_0000, 1'b0},
      '{32'sh7fff_ffff, 1'b0, '0, 1'b0},
      '{32'sh7fff_ffff, 1'b0, '0, 1'b0},
      '{32'sh8000_0000, 1'b0, '0, 1'b0},
      '{32'sh8000_0000, 1'b0, '0, 1'b0},
      '{-32'sd1,        1'b0, '0, 1'b0},
      '{32'sd1,         1'b0, '0, 1'b0},
      '{-32'sd3,        1'b0, '0, 1'b0},
      '{32'sd5,         1'b0, '0, 1'b0},
      '{32'sd5,         1'b0, '0, 1'b0},
      '{32'sd5,         1'b0, '0, 1'b0},
      '{-32'sd7,        1'b0, '0, 1'b0},
      '{32'sd100,       1'b0, '0, 1'b0},
      '{-32'sd100,      1'b0, '0, 1'b0},
      '{32'sh5555_5555, 1'b0, '0, 1'b0},
      '{32'shaaaa_aaaa, 1'b0, '0, 1'b0},
      '{32'sd2,         1'b0, '0, 1'b0},
      '{32'sd3,         1'b0, '0, 1'b0}
    };
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_sample(dir_rows[i].smp, dir_rows[i].fixed, dir_rows[i].med, dir_rows[i].drp);

    for (int k = 0; k < N_RANDOM; k++) begin
      idling_on = !(k >= 600 && k < 900);
      if (k == 400) begin
        @(negedge clk_i);
        start <= 1'b0;
        while (pending_medians.size() != 0) @(posedge clk_i);
      end
      send_sample(random_sample(), 1'b0, '0, 1'b0);
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (pending_medians.size() != 0) report_mismatch("missing results", 0, pending_medians.size());

    $display("Sent %0d samples, checked %0d results, %0d of them dropped on a full set.",
             items_sent, results_seen, drops_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
